// File: design/vertex_transform_perspective_macros.svh
// Assertion shorthands shared by the checker.
`ifndef VERTEX_TRANSFORM_PERSPECTIVE_MACROS_SVH
`define VERTEX_TRANSFORM_PERSPECTIVE_MACROS_SVH

// Clocked on clk, quiet while rst is high.
`define VTP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked on clk, also checked during reset.
`define VTP_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: design/vtp_pkg.sv
package vtp_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int COORD_W       = 32;
  localparam int DATA_W        = 64;
  localparam int NUM_REGS      = 8;
  localparam int REG_IDX_W     = 3;
  localparam int ADDR_W        = 6;
  localparam int QUEUE_DEPTH   = 4;
  localparam int SUM_W         = 66;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_ROW0_C01 = 3'd0,
    REG_ROW0_C23 = 3'd1,
    REG_ROW1_C01 = 3'd2,
    REG_ROW1_C23 = 3'd3,
    REG_ROW2_C01 = 3'd4,
    REG_ROW2_C23 = 3'd5,
    REG_PERSP_XY = 3'd6,
    REG_PERSP_ZD = 3'd7
  } reg_idx_t;

  typedef logic [NUM_REGS-1:0][DATA_W-1:0] cfg_bank_t;

  localparam cfg_bank_t REG_RESET = {
    64'h0000_0000_0000_0000,   // persp_z_distance
    64'h0000_0000_0000_0000,   // persp_xy
    64'h0001_0000_0000_0000,   // row2_cols23
    64'h0000_0000_0000_0000,   // row2_cols01
    64'h0000_0000_0000_0000,   // row1_cols23
    64'h0000_0000_0001_0000,   // row1_cols01
    64'h0000_0000_0000_0000,   // row0_cols23
    64'h0000_0001_0000_0000    // row0_cols01
  };

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
    logic                      last;
  } vtx_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] ax;
    logic signed [COORD_W-1:0] ay;
    logic signed [COORD_W-1:0] az;
    logic [2:0]                neg;
    logic [2:0]                frac_nz;
    logic                      clip;
    logic                      persp;
    logic                      last;
  } side_t;

  typedef struct packed {
    logic                      ovf;
    logic signed [COORD_W-1:0] val;
  } sat_t;

  function automatic sat_t sat32(input logic signed [SUM_W-1:0] v);
    sat_t r;
    if (v > SUM_W'(signed'(32'sh7fff_ffff))) begin
      r.ovf = 1'b1;
      r.val = 32'sh7fff_ffff;
    end else if (v < SUM_W'(signed'(32'sh8000_0000))) begin
      r.ovf = 1'b1;
      r.val = 32'sh8000_0000;
    end else begin
      r.ovf = 1'b0;
      r.val = v[COORD_W-1:0];
    end
    return r;
  endfunction

endpackage

// File: design/vtp_front.sv
module vtp_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic signed [31:0]  in_x,
  input  logic signed [31:0]  in_y,
  input  logic signed [31:0]  in_z,
  input  logic                last_vertex,
  output logic                q_valid,
  output vtp_pkg::vtx_t       q_word,
  input  logic                q_take
);
  import vtp_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  vtx_t             slot [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;
  logic             pop;

  assign in_stall = (count == CNT_W'(QUEUE_DEPTH));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count != '0);
  assign pop      = q_valid && q_take;
  assign q_word   = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= '{x: in_x, y: in_y, z: in_z, last: last_vertex};
    end
  end

endmodule

// File: design/vtp_div.sv
// Restoring divider, one quotient bit per pipeline stage.
module vtp_div #(
  parameter int FRAC_BITS = vtp_pkg::FRAC_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   en,
  input  logic [62-FRAC_BITS:0]  dvd_in,
  input  logic [31:0]            dsr,
  output logic [62-FRAC_BITS:0]  quo,
  output logic [31:0]            rem
);
  import vtp_pkg::*;

  localparam int NB = 63 - FRAC_BITS;

  logic [31:0]   rem_r [NB];
  logic [NB-1:0] dvd_r [NB];
  logic [NB-1:0] quo_r [NB];

  for (genvar j = 0; j < NB; j++) begin : g_stage
    logic [31:0]   rem_p;
    logic [NB-1:0] dvd_p;
    logic [NB-1:0] quo_p;
    logic [32:0]   trial;
    logic          ge;

    if (j == 0) begin : g_first
      assign rem_p = '0;
      assign dvd_p = dvd_in;
      assign quo_p = '0;
    end else begin : g_next
      assign rem_p = rem_r[j-1];
      assign dvd_p = dvd_r[j-1];
      assign quo_p = quo_r[j-1];
    end

    assign trial = {rem_p, dvd_p[NB-1]};
    assign ge    = (trial >= {1'b0, dsr});

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[j] <= ge ? 32'(trial - {1'b0, dsr}) : trial[31:0];
        dvd_r[j] <= {dvd_p[NB-2:0], 1'b0};
        quo_r[j] <= {quo_p[NB-2:0], ge};
      end
    end
  end

  assign quo = quo_r[NB-1];
  assign rem = rem_r[NB-1];

endmodule

// File: design/vtp_back.sv
module vtp_back #(
  parameter int FRAC_BITS = vtp_pkg::FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  vtp_pkg::cfg_bank_t  cfg,
  input  logic                q_valid,
  input  vtp_pkg::vtx_t       q_word,
  output logic                q_take,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [31:0]  out_x,
  output logic signed [31:0]  out_y,
  output logic signed [31:0]  out_z,
  output logic                clipped,
  output logic                last_out
);
  import vtp_pkg::*;

  localparam int NB = 63 - FRAC_BITS;

  logic en;
  assign en     = !out_valid || !out_stall;
  assign q_take = en;

  logic [31:0] distance;
  assign distance = cfg[REG_PERSP_ZD][31:0];

  // coefficient rows: x, y, z coords and the weight row
  logic signed [3:0][2:0][31:0] coef;
  logic signed [2:0][31:0]      trans;
  assign coef[0] = {cfg[REG_ROW0_C23][63:32], cfg[REG_ROW0_C01][31:0],
                    cfg[REG_ROW0_C01][63:32]};
  assign coef[1] = {cfg[REG_ROW1_C23][63:32], cfg[REG_ROW1_C01][31:0],
                    cfg[REG_ROW1_C01][63:32]};
  assign coef[2] = {cfg[REG_ROW2_C23][63:32], cfg[REG_ROW2_C01][31:0],
                    cfg[REG_ROW2_C01][63:32]};
  assign coef[3] = {cfg[REG_PERSP_ZD][63:32], cfg[REG_PERSP_XY][31:0],
                    cfg[REG_PERSP_XY][63:32]};
  assign trans   = {cfg[REG_ROW2_C23][31:0], cfg[REG_ROW1_C23][31:0],
                    cfg[REG_ROW0_C23][31:0]};

  // stage 1: twelve products
  logic                     v1;
  logic                     last1;
  logic signed [63:0]       prod1 [4][3];
  logic signed [COORD_W-1:0] in_c [3];
  assign in_c[0] = q_word.x;
  assign in_c[1] = q_word.y;
  assign in_c[2] = q_word.z;

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (en) v1 <= q_valid;
  end

  for (genvar r = 0; r < 4; r++) begin : g_prod
    for (genvar c = 0; c < 3; c++) begin : g_col
      always_ff @(posedge clk) begin
        if (en) prod1[r][c] <= 64'(signed'(coef[r][c])) * 64'(signed'(in_c[c]));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) last1 <= q_word.last;
  end

  // stage 2: exact sums, one floor shift, saturate
  logic                      v2;
  logic                      last2;
  logic                      clip2;
  logic signed [COORD_W-1:0] a2 [3];
  logic signed [COORD_W-1:0] w2;
  sat_t                      s2 [4];

  for (genvar r = 0; r < 4; r++) begin : g_sum
    logic signed [SUM_W-1:0] sum;
    logic signed [SUM_W-1:0] base;
    if (r < 3) begin : g_aff
      assign base = SUM_W'(signed'(trans[r]));
    end else begin : g_w
      assign base = SUM_W'(1) << FRAC_BITS;
    end
    assign sum = SUM_W'(prod1[r][0]) + SUM_W'(prod1[r][1]) + SUM_W'(prod1[r][2]);
    assign s2[r] = sat32((sum >>> FRAC_BITS) + base);
  end

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (en) v2 <= v1;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a2[0] <= s2[0].val;
      a2[1] <= s2[1].val;
      a2[2] <= s2[2].val;
      w2    <= s2[3].val;     // weight overflow never flags
      clip2 <= s2[0].ovf || s2[1].ovf || s2[2].ovf;
      last2 <= last1;
    end
  end

  // stage 3: a * w
  logic                      v3;
  logic                      last3;
  logic                      clip3;
  logic signed [COORD_W-1:0] a3 [3];
  logic signed [63:0]        t3 [3];

  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else if (en) v3 <= v2;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        a3[i] <= a2[i];
        t3[i] <= 64'(a2[i]) * 64'(w2);
      end
      clip3 <= clip2;
      last3 <= last2;
    end
  end

  // stage 4: split t / (D * 2^F) into a floor shift and a magnitude divide by D
  logic          v4;
  side_t         side4;
  logic [NB-1:0] mag4 [3];

  always_ff @(posedge clk) begin
    if (rst) v4 <= 1'b0;
    else if (en) v4 <= v3;
  end

  always_ff @(posedge clk) begin
    logic signed [63:0] tf;
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        tf                = t3[i] >>> FRAC_BITS;
        mag4[i]          <= t3[i][63] ? NB'(-tf) : NB'(tf);
        side4.neg[i]     <= t3[i][63];
        side4.frac_nz[i] <= |t3[i][FRAC_BITS-1:0];
      end
      side4.ax    <= a3[0];
      side4.ay    <= a3[1];
      side4.az    <= a3[2];
      side4.clip  <= clip3;
      side4.persp <= (distance != '0);
      side4.last  <= last3;
    end
  end

  logic [NB-1:0] quo [3];
  logic [31:0]   rem [3];

  for (genvar i = 0; i < 3; i++) begin : g_div
    vtp_div #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clk    (clk),
      .en     (en),
      .dvd_in (mag4[i]),
      .dsr    (distance),
      .quo    (quo[i]),
      .rem    (rem[i])
    );
  end

  // side band runs alongside the divider stages
  side_t side_d [NB];
  logic  vld_d  [NB];

  for (genvar j = 0; j < NB; j++) begin : g_dly
    always_ff @(posedge clk) begin
      if (rst) vld_d[j] <= 1'b0;
      else if (en) vld_d[j] <= (j == 0) ? v4 : vld_d[(j == 0) ? 0 : j-1];
    end
    always_ff @(posedge clk) begin
      if (en) side_d[j] <= (j == 0) ? side4 : side_d[(j == 0) ? 0 : j-1];
    end
  end

  // final: a + floor(t/k), then toward zero, then saturate
  side_t                     sf;
  logic signed [COORD_W-1:0] af [3];
  sat_t                      res [3];
  assign sf    = side_d[NB-1];
  assign af[0] = sf.ax;
  assign af[1] = sf.ay;
  assign af[2] = sf.az;

  for (genvar i = 0; i < 3; i++) begin : g_fin
    logic               rnz;
    logic               inexact;
    logic signed [63:0] q;
    logic signed [63:0] f;
    assign rnz     = (rem[i] != '0);
    assign inexact = rnz || sf.frac_nz[i];
    assign q = sf.neg[i] ? -(64'(quo[i]) + 64'(rnz)) : 64'(quo[i]);
    assign f = 64'(af[i]) + q;
    assign res[i] = sat32(SUM_W'((f < 0 && inexact) ? f + 64'sd1 : f));
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= vld_d[NB-1];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (sf.persp) begin
        out_x   <= res[0].val;
        out_y   <= res[1].val;
        out_z   <= res[2].val;
        clipped <= sf.clip || res[0].ovf || res[1].ovf || res[2].ovf;
      end else begin
        out_x   <= sf.ax;
        out_y   <= sf.ay;
        out_z   <= sf.az;
        clipped <= sf.clip;
      end
      last_out <= sf.last;
    end
  end

endmodule

// File: design/vertex_transform_perspective.sv
// Vertex transform with optional perspective scaling. One vertex enters per
// cycle and one result leaves per cycle while out_stall stays low; out_valid
// rises once its vertex has left the 4-entry input queue and passed stages 1
// to 4, the divider stages and the output register. Most of that depth is set
// by the pipelined restoring divider for the division by the distance, one
// quotient bit per stage, three in parallel. A held out_stall with out_valid high
// freezes the whole back pipeline; the input queue keeps taking vertices until it
// fills. Registers are 64 bits at byte address 8*index and may only be written
// while no vertex is in flight.
module vertex_transform_perspective #(
  parameter int FRAC_BITS = vtp_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [vtp_pkg::ADDR_W-1:0]  paddr,
  input  logic [vtp_pkg::DATA_W-1:0]  pwdata,
  output logic [vtp_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic signed [31:0]          in_x,
  input  logic signed [31:0]          in_y,
  input  logic signed [31:0]          in_z,
  input  logic                        last_vertex,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic signed [31:0]          out_x,
  output logic signed [31:0]          out_y,
  output logic signed [31:0]          out_z,
  output logic                        clipped,
  output logic                        last_out
);
  import vtp_pkg::*;

  cfg_bank_t            cfg;
  logic [REG_IDX_W-1:0] idx;

  assign idx    = paddr[ADDR_W-1:ADDR_W-REG_IDX_W];
  assign pready = 1'b1;
  assign prdata = cfg[idx];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= REG_RESET;
    end else if (psel && penable && pwrite && pready) begin
      cfg[idx] <= pwdata;
    end
  end

  logic q_valid;
  logic q_take;
  vtx_t q_word;

  vtp_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_x        (in_x),
    .in_y        (in_y),
    .in_z        (in_z),
    .last_vertex (last_vertex),
    .q_valid     (q_valid),
    .q_word      (q_word),
    .q_take      (q_take)
  );

  vtp_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_word    (q_word),
    .q_take    (q_take),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_x     (out_x),
    .out_y     (out_y),
    .out_z     (out_z),
    .clipped   (clipped),
    .last_out  (last_out)
  );

endmodule

// File: design/vtp_checker.sv
`include "vertex_transform_perspective_macros.svh"

module vtp_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        psel,
  input logic                        penable,
  input logic                        pwrite,
  input logic [vtp_pkg::ADDR_W-1:0]  paddr,
  input logic [vtp_pkg::DATA_W-1:0]  pwdata,
  input logic [vtp_pkg::DATA_W-1:0]  prdata,
  input logic                        pready,
  input logic                        in_valid,
  input logic                        in_stall,
  input logic signed [31:0]          in_x,
  input logic signed [31:0]          in_y,
  input logic signed [31:0]          in_z,
  input logic                        last_vertex,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic signed [31:0]          out_x,
  input logic signed [31:0]          out_y,
  input logic signed [31:0]          out_z,
  input logic                        clipped,
  input logic                        last_out
);
  import vtp_pkg::*;

  `VTP_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_x), "stalled word dropped")
  `VTP_ASSERT(a_hs_known, !$isunknown(out_valid) && !$isunknown(in_stall), "handshake unknown")
  `VTP_ASSERT_ALWAYS(a_rst_empty, $past(rst) && !rst |-> !out_valid && !in_stall, "pipeline not empty after reset")
  `VTP_ASSERT_ALWAYS(a_pready, pready, "pready low")

endmodule

bind vertex_transform_perspective vtp_checker u_vtp_checker (.*);

// File: tb/tb_vertex_transform_perspective.sv
module tb_vertex_transform_perspective;
  timeunit 1ns;
  timeprecision 1ps;
  import vtp_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [31:0] in_x = '0, in_y = '0, in_z = '0;
  logic last_vertex = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] out_x, out_y, out_z;
  logic clipped, last_out;

  typedef struct {
    logic signed [31:0] x, y, z;
    logic clip, last;
  } vout_t;

  logic [DATA_W-1:0] coef_bank [NUM_REGS];
  vout_t expected_q[$];
  int n_fail = 0;
  bit sender_busy = 1'b1;  // random gaps on the sender
  bit sink_busy = 1'b1;    // random stalls on the receiver
  int hold_off = 0;        // long receiver hold-off, in cycles

  vertex_transform_perspective dut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    #8ms;
    $display("TB_ERROR");
    $finish;
  end

  function automatic longint signed half32(logic [63:0] r, bit upper);
    logic signed [31:0] h;
    h = upper ? r[63:32] : r[31:0];
    return longint'(h);
  endfunction

  // exact floor((a*x + b*y + c*z) / 2^16) + t, in 128 bits
  function automatic logic signed [127:0] dot_floor(longint signed a, longint signed b,
      longint signed c, longint signed x, longint signed y, longint signed z,
      longint signed t);
    logic signed [127:0] s;
    s = 128'(a) * 128'(x) + 128'(b) * 128'(y) + 128'(c) * 128'(z);
    return (s >>> 16) + 128'(t);
  endfunction

  function automatic logic signed [127:0] clamp32(logic signed [127:0] v, ref bit flag);
    if (v > 128'sd2147483647) begin flag = 1; return 128'sd2147483647; end
    if (v < -128'sd2147483648) begin flag = 1; return -128'sd2147483648; end
    return v;
  endfunction

  function automatic vout_t transform_vertex(logic signed [31:0] x, logic signed [31:0] y,
      logic signed [31:0] z, logic last);
    vout_t o;
    bit clip, dummy;
    logic signed [127:0] v[3];
    logic signed [127:0] w, k, t, q;
    logic [31:0] distance;
    clip = 0;
    dummy = 0;
    for (int i = 0; i < 3; i++)
      v[i] = clamp32(dot_floor(half32(coef_bank[2*i], 1), half32(coef_bank[2*i], 0),
          half32(coef_bank[2*i+1], 1), x, y, z, half32(coef_bank[2*i+1], 0)), clip);
    distance = coef_bank[REG_PERSP_ZD][31:0];
    if (distance != 0) begin
      k = 128'(distance) <<< 16;
      w = clamp32(dot_floor(half32(coef_bank[REG_PERSP_XY], 1),
          half32(coef_bank[REG_PERSP_XY], 0), half32(coef_bank[REG_PERSP_ZD], 1),
          x, y, z, 65536), dummy);
      for (int i = 0; i < 3; i++) begin
        t = v[i] * (k + w);
        q = t / k;  // SV division truncates toward zero
        v[i] = clamp32(q, clip);
      end
    end
    o.x = v[0][31:0];
    o.y = v[1][31:0];
    o.z = v[2][31:0];
    o.clip = clip;
    o.last = last;
    return o;
  endfunction

  task automatic write_reg(reg_idx_t idx, logic [63:0] val);
    @(negedge clk);
    psel <= 1; penable <= 0; pwrite <= 1;
    paddr <= ADDR_W'(8 * int'(idx)); pwdata <= val;
    @(negedge clk);
    penable <= 1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    coef_bank[idx] = val;
  endtask

  // returns at the accepting edge with valid still high, so the next word can follow
  task automatic send_vertex(logic signed [31:0] x, logic signed [31:0] y,
      logic signed [31:0] z, logic last);
    @(negedge clk);
    while (sender_busy && $urandom_range(99) < 22) begin
      in_valid <= 0;
      @(negedge clk);
    end
    in_valid <= 1; in_x <= x; in_y <= y; in_z <= z; last_vertex <= last;
    do @(posedge clk); while (in_stall);
    expected_q.push_back(transform_vertex(x, y, z, last));
  endtask

  // n random vertices, small or full-range coordinates, random last flags
  task automatic send_burst(int n, bit smallish);
    logic signed [31:0] c[3];
    for (int i = 0; i < n; i++) begin
      for (int j = 0; j < 3; j++)
        c[j] = smallish ? $signed($urandom_range(0, 32'h000f_ffff)) - 32'sh0008_0000
                        : $urandom;
      send_vertex(c[0], c[1], c[2], $urandom_range(7) == 0);
    end
  endtask

  task automatic drain;
    int guard;
    guard = 0;
    @(negedge clk);
    in_valid <= 0;
    while (expected_q.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    if (expected_q.size() != 0) begin
      $display("TB_ERROR");
      $finish;
    end
    repeat (80) @(posedge clk);
  endtask

  // receiver
  always @(negedge clk) begin
    if (hold_off > 0) begin
      out_stall <= 1;
      hold_off <= hold_off - 1;
    end else
      out_stall <= sink_busy && ($urandom_range(99) < 22);
  end

  always @(posedge clk) begin
    vout_t e;
    if (!rst && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        $error("unexpected word x=%0d", out_x);
        n_fail++;
      end else begin
        e = expected_q.pop_front();
        if (out_x !== e.x) begin $error("out_x exp %0d got %0d", e.x, out_x); n_fail++; end
        if (out_y !== e.y) begin $error("out_y exp %0d got %0d", e.y, out_y); n_fail++; end
        if (out_z !== e.z) begin $error("out_z exp %0d got %0d", e.z, out_z); n_fail++; end
        if (clipped !== e.clip) begin
          $error("clipped exp %0b got %0b", e.clip, clipped); n_fail++;
        end
        if (last_out !== e.last) begin
          $error("last_out exp %0b got %0b", e.last, last_out); n_fail++;
        end
      end
    end
  end

  function automatic logic [63:0] pack2(logic [31:0] hi, logic [31:0] lo);
    return {hi, lo};
  endfunction

  task automatic test_identity_extremes;
    send_vertex(0, 0, 0, 0);
    send_vertex(32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff, 1);
    send_vertex(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 0);
    send_vertex(32'sh0001_0000, -32'sh0001_0000, 32'sh0000_8000, 1);
    send_vertex(-1, 1, -1, 0);
    drain();
  endtask

  task automatic test_affine_saturation;
    write_reg(REG_ROW0_C01, pack2(32'h7fff_ffff, 32'h7fff_ffff));
    write_reg(REG_ROW0_C23, pack2(32'h7fff_ffff, 32'h7fff_ffff));
    write_reg(REG_ROW1_C01, pack2(32'h8000_0000, 32'h8000_0000));
    write_reg(REG_ROW1_C23, pack2(32'h8000_0000, 32'h8000_0000));
    write_reg(REG_ROW2_C01, pack2(32'hffff_8000, 32'h0000_8000));
    write_reg(REG_ROW2_C23, pack2(32'h0002_0000, 32'hffff_ffff));
    send_vertex(32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff, 0);
    send_vertex(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 1);
    send_vertex(32'sh8000_0000, 32'sh7fff_ffff, 0, 0);
    send_vertex(3, -5, 7, 1);  // floor rounding of tiny products
    send_vertex(0, 0, 0, 0);
    drain();
  endtask

  task automatic test_perspective;
    // identity matrix with small x and y offsets and distance 1, then weight pushing factor to zero / negative
    write_reg(REG_ROW0_C01, pack2(32'h0001_0000, 0));
    write_reg(REG_ROW0_C23, pack2(0, 32'h0000_1000));
    write_reg(REG_ROW1_C01, pack2(0, 32'h0001_0000));
    write_reg(REG_ROW1_C23, pack2(0, 32'hffff_f000));
    write_reg(REG_ROW2_C01, pack2(0, 0));
    write_reg(REG_ROW2_C23, pack2(32'h0001_0000, 0));
    write_reg(REG_PERSP_XY, pack2(32'h0001_0000, 0));
    write_reg(REG_PERSP_ZD, pack2(32'h0000_0000, 32'd1));
    send_vertex(32'sh0001_0000, 32'sh0002_0000, -32'sh0003_0000, 0);
    send_vertex(-32'sh0002_0000, 32'sh0001_0000, 32'sh0001_0000, 1);  // factor zero
    send_vertex(-32'sh0005_0000, -32'sh0001_8000, 32'sh0000_0001, 0); // negative factor
    send_vertex(32'sh7fff_ffff, 32'sh0100_0000, 32'sh0100_0000, 1);   // weight saturates
    send_vertex(32'sh8000_0000, 32'sh8000_0000, 32'sh7fff_ffff, 0);
    drain();
    write_reg(REG_PERSP_XY, pack2(32'h8000_0000, 32'h7fff_ffff));
    write_reg(REG_PERSP_ZD, pack2(32'h8000_0000, 32'hffff_ffff));
    send_vertex(32'sh7fff_ffff, -32'sh0000_0001, 32'sh1234_5678, 1);
    send_vertex(32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000, 0);
    send_vertex(-7, 9, -11, 1);
    drain();
  endtask

  task automatic randomize_bank(bit wild);
    for (int i = 0; i < NUM_REGS; i++) begin
      logic [63:0] v;
      v = {$urandom, $urandom};
      if (!wild) begin
        v[63:32] = $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
        v[31:0] = $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
        if (i == int'(REG_PERSP_ZD)) v[31:0] = $urandom_range(3) == 0 ? 0 : $urandom_range(1, 2000);
      end
      write_reg(reg_idx_t'(i), v);
    end
  endtask

  task automatic test_random;
    for (int phase = 0; phase < 10; phase++) begin
      randomize_bank(phase % 3 == 2);
      if (phase == 4) begin
        sender_busy = 0; sink_busy = 0;
      end else begin
        sender_busy = 1; sink_busy = 1;
      end
      send_burst(100, phase % 2 == 0);
      drain();
    end
  endtask

  // more words than the pipeline and the queue hold together
  task automatic test_backpressure;
    fork
      hold_off = 300;
      send_burst(120, 1);
    join
    drain();
  endtask

  initial begin
    for (int i = 0; i < NUM_REGS; i++) coef_bank[i] = REG_RESET[i];
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    test_identity_extremes();
    test_affine_saturation();
    test_perspective();
    test_backpressure();
    test_random();
    if (n_fail == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end
endmodule
